// File: hdl/kvba_pkg.sv
`default_nettype none
package kvba_pkg;

  // table geometry
  localparam int KEY_COUNT = 1024;
  localparam int KEY_BITS  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  // block size is a power of two, given by its shift
  localparam int BLOCK_SHIFT = 12;
  localparam int BLOCK_BYTES = 1 << BLOCK_SHIFT;

  // field widths
  localparam int CMD_W  = 1;
  localparam int KEY_W  = 32;
  localparam int CNT_W  = 16;
  localparam int LEN_W  = 32;
  localparam int LBA_W  = 32;
  localparam int BCNT_W = 20;
  localparam int STS_W  = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_GET = 1'b1;

  // status codes
  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_BAD_KEY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL    = 2'd2;
  localparam logic [STS_W-1:0] STS_NO_KEY  = 2'd3;

  // register map
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 2'd0;
  localparam logic [LBA_W-1:0]   CAPACITY_RESET = 32'hFFFF_FFFF;

  localparam logic [LEN_W-1:0] LEN_SAT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic             valid;
    logic [LBA_W-1:0] start_lba;
    logic [LEN_W-1:0] length;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // table port requests from the engine
  typedef struct packed {
    logic                wr_en;
    logic [KEY_BITS-1:0] wr_addr;
    entry_t              wr_data;
    logic                rd_en;
    logic [KEY_BITS-1:0] rd_addr;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_BUSY  = 3'b100
  } eng_state_t;

endpackage
`default_nettype wire

// File: hdl/kvba_ram.sv
`default_nettype none
module kvba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  clk,
  wr_en,
  wr_addr,
  wr_data,
  rd_en,
  rd_addr,
  rd_data
);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  wire logic              clk;
  input  wire logic              wr_en;
  input  wire logic [ADDR_W-1:0] wr_addr;
  input  wire logic [WIDTH-1:0]  wr_data;
  input  wire logic              rd_en;
  input  wire logic [ADDR_W-1:0] rd_addr;
  output      logic [WIDTH-1:0]  rd_data;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/kvba_regs.sv
`default_nettype none
module kvba_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [kvba_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [kvba_pkg::PDATA_W-1:0]   pwdata,
  output      logic [kvba_pkg::PDATA_W-1:0]   prdata,
  output      logic                           pready,
  output      logic [kvba_pkg::LBA_W-1:0]     capacity_lba_limit
);
  import kvba_pkg::*;

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == ADDR_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_lba_limit <= CAPACITY_RESET;
    end else if (wr_hit) begin
      capacity_lba_limit <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_CAPACITY) begin
      prdata = capacity_lba_limit;
    end
  end

endmodule
`default_nettype wire

// File: hdl/kvba_engine.sv
`default_nettype none
module kvba_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [kvba_pkg::CMD_W-1:0]    command,
  input  wire logic [kvba_pkg::KEY_W-1:0]    key,
  input  wire logic [kvba_pkg::CNT_W-1:0]    block_count_minus_one,
  input  wire logic [kvba_pkg::LEN_W-1:0]    value_length,
  input  wire logic [kvba_pkg::LBA_W-1:0]    capacity_lba_limit,
  output      kvba_pkg::ram_req_t            ram_req,
  input  wire kvba_pkg::entry_t              ram_rdata,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [kvba_pkg::STS_W-1:0]    status,
  output      logic [kvba_pkg::LBA_W-1:0]    start_lba,
  output      logic [kvba_pkg::BCNT_W-1:0]   block_count_minus_one_out,
  output      logic [kvba_pkg::LEN_W-1:0]    value_length_out
);
  import kvba_pkg::*;

  eng_state_t state, state_next;
  logic [KEY_BITS-1:0] clr_addr;
  logic [LBA_W-1:0]    next_free_lba;

  // latched request
  logic [CMD_W-1:0] req_cmd;
  logic             req_key_ok;
  logic [KEY_BITS-1:0] req_addr;
  logic [CNT_W-1:0] req_cnt_m1;
  logic [LEN_W-1:0] req_vlen;

  logic in_fire, finish;
  logic [CNT_W:0]   count;
  logic [LBA_W:0]   end_lba;
  logic             put_full;
  logic             put_ok;
  logic [63:0]      bytes64;
  logic [LEN_W-1:0] put_len;
  logic [LEN_W-1:0] len_m1;
  logic [LEN_W-1:0] blocks;
  logic [BCNT_W-1:0] blocks_sat;

  logic [STS_W-1:0]  res_status;
  logic [LBA_W-1:0]  res_lba;
  logic [BCNT_W-1:0] res_bcnt;
  logic [LEN_W-1:0]  res_len;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign finish   = (state == ST_BUSY) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == KEY_BITS'(KEY_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_fire) state_next = ST_BUSY;
      ST_BUSY:  if (finish) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + KEY_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_cmd    <= command;
      req_key_ok <= (key < KEY_W'(KEY_COUNT));
      req_addr   <= key[KEY_BITS-1:0];
      req_cnt_m1 <= block_count_minus_one;
      req_vlen   <= value_length;
    end
  end

  // put: 33-bit end check and default length
  assign count    = {1'b0, req_cnt_m1} + (CNT_W+1)'(1);
  assign end_lba  = {1'b0, next_free_lba} + (LBA_W+1)'(count);
  assign put_full = end_lba > {1'b0, capacity_lba_limit};
  assign put_ok   = (req_cmd == CMD_PUT) && req_key_ok && !put_full;
  assign bytes64  = 64'(count) << BLOCK_SHIFT;

  always_comb begin
    if (req_vlen != '0) begin
      put_len = req_vlen;
    end else if (|bytes64[63:LEN_W]) begin
      put_len = LEN_SAT;
    end else begin
      put_len = bytes64[LEN_W-1:0];
    end
  end

  // get: (length - 1) / block size, saturated to the output field
  assign len_m1     = ram_rdata.length - LEN_W'(1);
  assign blocks     = len_m1 >> BLOCK_SHIFT;
  assign blocks_sat = (|blocks[LEN_W-1:BCNT_W]) ? {BCNT_W{1'b1}} : blocks[BCNT_W-1:0];

  always_comb begin
    res_status = STS_OK;
    res_lba    = '0;
    res_bcnt   = '0;
    res_len    = '0;
    if (req_cmd == CMD_PUT) begin
      if (!req_key_ok) begin
        res_status = STS_BAD_KEY;
      end else if (put_full) begin
        res_status = STS_FULL;
      end else begin
        res_lba = next_free_lba;
      end
    end else begin
      if (!req_key_ok || !ram_rdata.valid) begin
        res_status = STS_NO_KEY;
      end else begin
        res_lba  = ram_rdata.start_lba;
        res_bcnt = blocks_sat;
        res_len  = ram_rdata.length;
      end
    end
  end

  always_comb begin
    ram_req = '0;
    if (state == ST_CLEAR) begin
      ram_req.wr_en   = 1'b1;
      ram_req.wr_addr = clr_addr;
    end else if (finish && put_ok) begin
      ram_req.wr_en             = 1'b1;
      ram_req.wr_addr           = req_addr;
      ram_req.wr_data.valid     = 1'b1;
      ram_req.wr_data.start_lba = next_free_lba;
      ram_req.wr_data.length    = put_len;
    end
    ram_req.rd_en   = in_fire;
    ram_req.rd_addr = key[KEY_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free_lba <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (finish && put_ok) begin
        next_free_lba <= end_lba[LBA_W-1:0];
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status                    <= res_status;
      start_lba                 <= res_lba;
      block_count_minus_one_out <= res_bcnt;
      value_length_out          <= res_len;
    end
  end

`ifndef SYNTH
  a_fire_to_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_BUSY))
    else $error("accepted item did not start a lookup");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |-> (state != ST_IDLE))
    else $error("table written while idle");

  a_ptr_only_on_put: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && !$stable(next_free_lba)) |-> $past(finish && put_ok))
    else $error("allocation pointer moved without a successful put");

  a_ptr_within_limit: assert property (@(posedge clk) disable iff (rst)
    (finish && put_ok) |-> (end_lba <= {1'b0, capacity_lba_limit}))
    else $error("allocation beyond capacity limit");
`endif

endmodule
`default_nettype wire

// File: hdl/kv_index_bump_allocator_top.sv
`default_nettype none
// key-to-extent index with a bump allocator
// input channel (in_valid/in_ready): command, key, block_count_minus_one,
//   value_length; a put stores an extent for the key, a get looks it up
// output channel (out_valid/out_ready): status, start_lba,
//   block_count_minus_one_out, value_length_out; exactly one item per input item
// config: APB port, capacity_lba_limit at byte address 0, write only while idle
// result: the request is latched and the table read as an item is accepted; the
//   check, write back and result register follow, unless the output stalls
// pacing: the engine holds a single item and takes no new one until it has
//   finished the last; the table's registered read sets the pace
// reset: the valid flags in the table are swept to zero, one entry a cycle,
//   across all KEY_COUNT (1024) entries after rst falls; in_ready stays low meanwhile;
//   allocation pointer returns to zero, capacity limit to all ones
// stall: one finished item waits in the output register while the next item
//   is accepted; that item then waits in the engine until the output frees
module kv_index_bump_allocator_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [kvba_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [kvba_pkg::PDATA_W-1:0]  pwdata,
  output      logic [kvba_pkg::PDATA_W-1:0]  prdata,
  output      logic                          pready,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [kvba_pkg::CMD_W-1:0]    command,
  input  wire logic [kvba_pkg::KEY_W-1:0]    key,
  input  wire logic [kvba_pkg::CNT_W-1:0]    block_count_minus_one,
  input  wire logic [kvba_pkg::LEN_W-1:0]    value_length,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [kvba_pkg::STS_W-1:0]    status,
  output      logic [kvba_pkg::LBA_W-1:0]    start_lba,
  output      logic [kvba_pkg::BCNT_W-1:0]   block_count_minus_one_out,
  output      logic [kvba_pkg::LEN_W-1:0]    value_length_out
);
  import kvba_pkg::*;

  logic [LBA_W-1:0]   capacity_lba_limit;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  entry_t             ram_rdata;

  // capacity register
  kvba_regs u_regs (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .capacity_lba_limit(capacity_lba_limit)
  );

  // entry table: valid flag, start lba and length per key
  kvba_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(KEY_COUNT)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_req.wr_en),
    .wr_addr(ram_req.wr_addr),
    .wr_data(ram_req.wr_data),
    .rd_en  (ram_req.rd_en),
    .rd_addr(ram_req.rd_addr),
    .rd_data(ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // sequencer, allocator and result register
  kvba_engine u_engine (
    .clk                      (clk),
    .rst                      (rst),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .command                  (command),
    .key                      (key),
    .block_count_minus_one    (block_count_minus_one),
    .value_length             (value_length),
    .capacity_lba_limit       (capacity_lba_limit),
    .ram_req                  (ram_req),
    .ram_rdata                (ram_rdata),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .status                   (status),
    .start_lba                (start_lba),
    .block_count_minus_one_out(block_count_minus_one_out),
    .value_length_out         (value_length_out)
  );

endmodule
`default_nettype wire

// File: test/tb_top.sv
module tb_top;
  import kvba_pkg::*;

  // one command as queued for the driver, with the idle cycles before it
  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
    logic [LEN_W-1:0] vlen;
    int unsigned      gap;
  } kv_cmd_t;

  // one expected result item
  typedef struct packed {
    logic [STS_W-1:0]  sts;
    logic [LBA_W-1:0]  lba;
    logic [BCNT_W-1:0] bcnt;
    logic [LEN_W-1:0]  len;
  } kv_resp_t;

  // how hard both sides idle in the current phase
  typedef enum int {
    IDLE_NONE,
    IDLE_LIGHT,
    IDLE_HEAVY
  } idle_kind_t;

  logic clk;
  logic rst = 1'b1;

  // apb side
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // command channel
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] command  = CMD_PUT;
  logic [KEY_W-1:0] key      = '0;
  logic [CNT_W-1:0] block_count_minus_one = '0;
  logic [LEN_W-1:0] value_length = '0;

  // result channel
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STS_W-1:0]  status;
  logic [LBA_W-1:0]  start_lba;
  logic [BCNT_W-1:0] block_count_minus_one_out;
  logic [LEN_W-1:0]  value_length_out;

  kv_index_bump_allocator_top dut (
    .clk                       (clk),
    .rst                       (rst),
    .psel                      (psel),
    .penable                   (penable),
    .pwrite                    (pwrite),
    .paddr                     (paddr),
    .pwdata                    (pwdata),
    .prdata                    (prdata),
    .pready                    (pready),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .command                   (command),
    .key                       (key),
    .block_count_minus_one     (block_count_minus_one),
    .value_length              (value_length),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .status                    (status),
    .start_lba                 (start_lba),
    .block_count_minus_one_out (block_count_minus_one_out),
    .value_length_out          (value_length_out)
  );

  // our own copy of the index: valid flags, extents, bump pointer, limit
  bit               tbl_valid [KEY_COUNT];
  logic [LBA_W-1:0] tbl_lba   [KEY_COUNT];
  logic [LEN_W-1:0] tbl_len   [KEY_COUNT];
  logic [LBA_W-1:0] alloc_ptr = '0;
  logic [LBA_W-1:0] cap_limit = CAPACITY_RESET;

  kv_cmd_t    cmd_q[$];             // items waiting for the driver
  kv_resp_t   extent_results_q[$];  // expected results, oldest first
  idle_kind_t idle_mode = IDLE_NONE;
  int         error_count = 0;
  int         result_idx = 0;

  // driver state
  kv_cmd_t     cur_cmd;
  bit          drv_loaded = 1'b0;
  int unsigned drv_wait = 0;
  bit          drv_next;

  // monitor state
  int unsigned rdy_wait = 0;
  kv_resp_t    want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle cycles for one item, depending on the phase
  function automatic int unsigned draw_gap();
    case (idle_mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
      default:    return $urandom_range(0, 12);
    endcase
  endfunction

  function automatic void push_cmd(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                   logic [CNT_W-1:0] n, logic [LEN_W-1:0] v);
    kv_cmd_t r;
    r.cmd  = c;
    r.key  = k;
    r.cnt  = n;
    r.vlen = v;
    r.gap  = draw_gap();
    cmd_q.push_back(r);
  endfunction

  // apply one command to the index copy and return the result it should give
  function automatic kv_resp_t apply_command(kv_cmd_t r);
    kv_resp_t         res;
    logic [LBA_W:0]   end_lba;
    logic [63:0]      bytes;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] blocks;
    res = '0;
    if (r.cmd == CMD_PUT) begin
      if (r.key >= KEY_COUNT) begin
        res.sts = STS_BAD_KEY;
      end else begin
        // 33-bit end, so the pointer never wraps past the limit
        end_lba = {1'b0, alloc_ptr} + (LBA_W+1)'(r.cnt) + (LBA_W+1)'(1);
        if (end_lba > {1'b0, cap_limit}) begin
          res.sts = STS_FULL;
        end else begin
          len = r.vlen;
          if (len == '0) begin
            // zero length means whole blocks, saturating at 32 bits
            bytes = (64'(r.cnt) + 64'd1) * 64'(BLOCK_BYTES);
            len = (bytes > 64'hFFFF_FFFF) ? LEN_SAT : bytes[LEN_W-1:0];
          end
          tbl_valid[r.key[KEY_BITS-1:0]] = 1'b1;
          tbl_lba[r.key[KEY_BITS-1:0]]   = alloc_ptr;
          tbl_len[r.key[KEY_BITS-1:0]]   = len;
          res.sts   = STS_OK;
          res.lba   = alloc_ptr;
          alloc_ptr = end_lba[LBA_W-1:0];
        end
      end
    end else begin
      if (r.key >= KEY_COUNT || !tbl_valid[r.key[KEY_BITS-1:0]]) begin
        res.sts = STS_NO_KEY;
      end else begin
        len    = tbl_len[r.key[KEY_BITS-1:0]];
        // length minus one wraps at 32 bits, count saturates at 20 bits
        blocks = (len - 32'd1) / LEN_W'(BLOCK_BYTES);
        res.sts  = STS_OK;
        res.lba  = tbl_lba[r.key[KEY_BITS-1:0]];
        res.bcnt = (blocks > 32'hF_FFFF) ? '1 : blocks[BCNT_W-1:0];
        res.len  = len;
      end
    end
    return res;
  endfunction

  task automatic flag_error(input string msg);
    $display("error: result %0d: %s", result_idx, msg);
    error_count++;
  endtask

  // apb write: setup cycle, then access cycle held until pready
  task automatic write_capacity(input logic [LBA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_limit = value;
  endtask

  // idle means nothing queued, nothing on the wire and nothing outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_q.size() != 0 || drv_loaded || in_valid || extent_results_q.size() != 0);
  endtask

  // driver: one item held at a time, valid raised after its gap and
  // held with a stable payload until accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      drv_loaded = 1'b0;
      drv_wait   = 0;
    end else begin
      if (in_valid && in_ready) begin
        // predict at acceptance, so config writes between phases line up
        extent_results_q.push_back(apply_command(cur_cmd));
        drv_loaded = 1'b0;
      end
      if (!drv_loaded && cmd_q.size() != 0) begin
        cur_cmd    = cmd_q.pop_front();
        drv_loaded = 1'b1;
        drv_wait   = cur_cmd.gap;
      end
      if (drv_loaded && drv_wait > 0) begin
        drv_wait--;
        drv_next = 1'b0;
      end else begin
        drv_next = drv_loaded;
      end
      // single assignment to valid per edge
      in_valid <= drv_next;
      if (drv_next) begin
        command               <= cur_cmd.cmd;
        key                   <= cur_cmd.key;
        block_count_minus_one <= cur_cmd.cnt;
        value_length          <= cur_cmd.vlen;
      end
    end
  end

  // monitor: compare each accepted result with the oldest expectation,
  // then drop ready for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rdy_wait  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (extent_results_q.size() == 0) begin
          flag_error("result with nothing expected");
        end else begin
          want = extent_results_q.pop_front();
          if (status !== want.sts)
            flag_error($sformatf("status %0d, want %0d", status, want.sts));
          if (start_lba !== want.lba)
            flag_error($sformatf("start_lba %h, want %h", start_lba, want.lba));
          if (block_count_minus_one_out !== want.bcnt)
            flag_error($sformatf("block count %h, want %h",
                                 block_count_minus_one_out, want.bcnt));
          if (value_length_out !== want.len)
            flag_error($sformatf("value length %h, want %h", value_length_out, want.len));
        end
        result_idx++;
        rdy_wait = draw_gap();
      end
      if (rdy_wait > 0) begin
        rdy_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus and phase control
  initial begin
    logic [LBA_W-1:0] new_cap;
    logic [KEY_W-1:0] k;
    logic [CNT_W-1:0] n;
    logic [LEN_W-1:0] v;
    int ph;
    int i;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // the table sweep keeps in_ready low for a while after reset
    do @(negedge clk); while (!in_ready);

    // directed: empty table, key range edges, default lengths, overwrite
    idle_mode = IDLE_NONE;
    push_cmd(CMD_GET, 32'd0, '0, '0);
    push_cmd(CMD_GET, '1, '0, '0);
    push_cmd(CMD_PUT, KEY_W'(KEY_COUNT), '0, '0);
    push_cmd(CMD_PUT, '1, '1, '1);
    push_cmd(CMD_PUT, 32'd0, '0, '0);
    push_cmd(CMD_PUT, KEY_W'(KEY_COUNT - 1), '1, '0);
    push_cmd(CMD_PUT, 32'd1, '0, '1);
    push_cmd(CMD_PUT, 32'd2, 16'd3, 32'd1);
    push_cmd(CMD_GET, 32'd0, '0, '0);
    push_cmd(CMD_GET, KEY_W'(KEY_COUNT - 1), '0, '0);
    push_cmd(CMD_GET, 32'd1, '0, '0);
    push_cmd(CMD_GET, 32'd2, '1, '1);
    push_cmd(CMD_GET, KEY_W'(KEY_COUNT - 2), '0, '0);
    push_cmd(CMD_GET, KEY_W'(KEY_COUNT), '0, '0);
    push_cmd(CMD_PUT, 32'd0, 16'd7, 32'd4097);
    push_cmd(CMD_GET, 32'd0, '0, '0);
    wait_drained();

    // limit just ten blocks ahead: exact fit, then full
    write_capacity(alloc_ptr + 32'd10);
    push_cmd(CMD_PUT, 32'd5, 16'd9, '0);
    push_cmd(CMD_PUT, 32'd6, 16'd0, '0);
    push_cmd(CMD_GET, 32'd5, '0, '0);
    push_cmd(CMD_GET, 32'd6, '0, '0);
    wait_drained();

    // limit dropped below the pointer: puts fail, gets still served
    write_capacity('0);
    push_cmd(CMD_PUT, 32'd7, 16'd0, 32'd100);
    push_cmd(CMD_GET, 32'd7, '0, '0);
    push_cmd(CMD_GET, 32'd5, '0, '0);
    wait_drained();

    // random phases, each with its own limit and idling pattern
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 6:    new_cap = '1;                                     // no limit
        1, 4, 7: new_cap = alloc_ptr + $urandom_range(0, 3000);    // fills up soon
        2:       new_cap = '0;
        3:       new_cap = alloc_ptr + $urandom_range(65536, 1 << 24);
        default: new_cap = (alloc_ptr == '0) ? '0 : alloc_ptr - 32'd1;
      endcase
      write_capacity(new_cap);
      idle_mode = idle_kind_t'(ph % 3);

      for (i = 0; i < 230; i++) begin
        // keys: mostly in range, often a small hot set so gets find entries
        case ($urandom_range(0, 9))
          0:       k = $urandom;
          1:       k = KEY_W'(KEY_COUNT) + $urandom_range(0, 3);
          2, 3, 4: k = $urandom_range(0, 15);
          default: k = $urandom_range(0, KEY_COUNT - 1);
        endcase
        case ($urandom_range(0, 7))
          0:       n = '1;
          1:       n = $urandom;
          2, 3:    n = $urandom_range(0, 15);
          default: n = $urandom_range(0, 255);
        endcase
        case ($urandom_range(0, 5))
          0, 1:    v = '0;
          2:       v = $urandom;
          3:       v = '1;
          4:       v = $urandom_range(1, 4096);
          default: v = $urandom_range(1, 1 << 20);
        endcase
        push_cmd($urandom_range(0, 1) ? CMD_GET : CMD_PUT, k, n, v);
      end
      wait_drained();
    end

    // let any stray result show up before the verdict
    repeat (10) @(posedge clk);
    if (extent_results_q.size() != 0)
      flag_error("expected results never arrived");
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: kv_index_bump_allocator_top.f
hdl/kvba_pkg.sv
hdl/kvba_ram.sv
hdl/kvba_regs.sv
hdl/kvba_engine.sv
hdl/kv_index_bump_allocator_top.sv
test/tb_top.sv
